/* rtl/bsc_pkg.sv */
`timescale 1ns / 1ps
package bsc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_SUB,
        ST_T_MUL,
        ST_T_DEN,
        ST_T_DIV,
        ST_T_WAIT,
        ST_T_END,
        ST_P_B6,
        ST_P_SQ,
        ST_P_X1,
        ST_P_X2,
        ST_P_B3,
        ST_P_X1B,
        ST_P_X2B,
        ST_P_B4,
        ST_P_B7,
        ST_P_DIV,
        ST_P_WAIT,
        ST_P_Q,
        ST_P_F1,
        ST_P_F2,
        ST_P_F3,
        ST_P_END,
        ST_OUT
    } state_t;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [31:0] C_4000  = 32'd4000;
    localparam logic [31:0] C_3038  = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] C_3791  = 32'd3791;
    localparam logic [31:0] C_50000 = 32'd50000;
    localparam logic [31:0] C_32768 = 32'd32768;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

/* rtl/bsc_div.sv */
`timescale 1ns / 1ps
module bsc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    assign busy = (cnt_reg != 6'd0);
    assign quotient = q_reg;
    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 6'd32;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

/* rtl/bsc_mul.sv */
`timescale 1ns / 1ps
module bsc_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    logic [31:0] p_reg;
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end
    assign p = p_reg;
endmodule

/* rtl/barometric_sensor_compensation.sv */
`timescale 1ns / 1ps
// Compensates raw temperature (tuser=0) and pressure (tuser=1) samples with the
// calibration words from the config port; one result beat per input beat. A
// single 32x32 multiplier and a radix-2 divider are sequenced, and the divider
// takes most of an item's time; a new sample is accepted only in idle. A
// temperature sample without a zero divisor updates the stored b5 used by
// later pressure samples. Zero divisor gives value 0 with the error flag.
module barometric_sensor_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // raw_sample
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [1:0]  m_axis_tuser    // div_error, kind
);
    bsc_pkg::state_t state_reg, state_next;
    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic [1:0]  oss_reg;
    logic [31:0] b5_reg, b5_next;
    logic [23:0] raw_reg, raw_next;
    logic        cmd_reg, cmd_next;
    logic [31:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic [31:0] val_reg, val_next;
    logic        err_reg, err_next;
    logic        neg_reg, neg_next;
    logic [31:0] ma, mb, mp;
    logic        dstart, dbusy;
    logic [31:0] dnum, dden, dq;

    bsc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
    bsc_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dnum),
                   .divisor(dden), .busy(dbusy), .quotient(dq));

    assign s_axis_tready = (state_reg == bsc_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == bsc_pkg::ST_OUT);
    assign m_axis_tdata  = val_reg;
    assign m_axis_tuser  = {err_reg, cmd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsc_pkg::ST_IDLE;
            r0_reg <= '0;
            r1_reg <= '0;
            r2_reg <= '0;
            r3_reg <= '0;
            r4_reg <= '0;
            oss_reg <= '0;
            b5_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            b5_reg <= b5_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bsc_pkg::REG_AC1_AC2: r0_reg <= cfg_data;
                    bsc_pkg::REG_AC3_AC4: r1_reg <= cfg_data;
                    bsc_pkg::REG_AC5_AC6: r2_reg <= cfg_data;
                    bsc_pkg::REG_B1_B2:   r3_reg <= cfg_data;
                    bsc_pkg::REG_MC_MD:   r4_reg <= cfg_data;
                    bsc_pkg::REG_OSS:     oss_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        cmd_reg <= cmd_next;
        t0_reg <= t0_next;
        t1_reg <= t1_next;
        t2_reg <= t2_next;
        t3_reg <= t3_next;
        val_reg <= val_next;
        err_reg <= err_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] up, x, na, nd;
        ac1 = bsc_pkg::sx16(r0_reg[15:0]);
        ac2 = bsc_pkg::sx16(r0_reg[31:16]);
        ac3 = bsc_pkg::sx16(r1_reg[15:0]);
        ac4 = {16'd0, r1_reg[31:16]};
        ac5 = {16'd0, r2_reg[15:0]};
        ac6 = {16'd0, r2_reg[31:16]};
        b1  = bsc_pkg::sx16(r3_reg[15:0]);
        b2  = bsc_pkg::sx16(r3_reg[31:16]);
        mc  = bsc_pkg::sx16(r4_reg[15:0]);
        md  = bsc_pkg::sx16(r4_reg[31:16]);
        up  = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});
        x   = '0;
        na  = '0;
        nd  = '0;
        state_next = state_reg;
        b5_next = b5_reg;
        raw_next = raw_reg;
        cmd_next = cmd_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        t3_next = t3_reg;
        val_next = val_reg;
        err_next = err_reg;
        neg_next = neg_reg;
        ma = '0;
        mb = '0;
        dstart = 1'b0;
        dnum = '0;
        dden = '0;
        case (state_reg)
            bsc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    raw_next = s_axis_tdata;
                    cmd_next = s_axis_tuser;
                    val_next = '0;
                    err_next = 1'b0;
                    state_next = s_axis_tuser ? bsc_pkg::ST_P_B6 : bsc_pkg::ST_T_SUB;
                end
            end
            bsc_pkg::ST_T_SUB:
            begin
                ma = {16'd0, raw_reg[15:0]} - ac6;
                mb = ac5;
                state_next = bsc_pkg::ST_T_MUL;
            end
            bsc_pkg::ST_T_MUL:
            begin
                t0_next = bsc_pkg::asr(mp, 5'd15);
                state_next = bsc_pkg::ST_T_DEN;
            end
            bsc_pkg::ST_T_DEN:
            begin
                t1_next = t0_reg + md;
                state_next = bsc_pkg::ST_T_DIV;
            end
            bsc_pkg::ST_T_DIV:
            begin
                if (t1_reg == '0)
                begin
                    err_next = 1'b1;
                    state_next = bsc_pkg::ST_OUT;
                end
                else
                begin
                    x = mc << 11;
                    na = x[31] ? -x : x;
                    nd = t1_reg[31] ? -t1_reg : t1_reg;
                    neg_next = x[31] ^ t1_reg[31];
                    dnum = na;
                    dden = nd;
                    dstart = 1'b1;
                    state_next = bsc_pkg::ST_T_WAIT;
                end
            end
            bsc_pkg::ST_T_WAIT:
            begin
                if (!dbusy)
                    state_next = bsc_pkg::ST_T_END;
            end
            bsc_pkg::ST_T_END:
            begin
                x = t0_reg + (neg_reg ? -dq : dq);
                b5_next = x;
                val_next = bsc_pkg::asr(x + 32'd8, 5'd4);
                state_next = bsc_pkg::ST_OUT;
            end
            bsc_pkg::ST_P_B6:
            begin
                t0_next = b5_reg - bsc_pkg::C_4000;
                state_next = bsc_pkg::ST_P_SQ;
            end
            bsc_pkg::ST_P_SQ:
            begin
                ma = t0_reg;
                mb = t0_reg;
                state_next = bsc_pkg::ST_P_X1;
            end
            // t1 = sq
            bsc_pkg::ST_P_X1:
            begin
                t1_next = bsc_pkg::asr(mp, 5'd12);
                ma = ac2;
                mb = t0_reg;
                state_next = bsc_pkg::ST_P_X2;
            end
            bsc_pkg::ST_P_X2:
            begin
                t2_next = bsc_pkg::asr(mp, 5'd11);
                ma = b2;
                mb = t1_reg;
                state_next = bsc_pkg::ST_P_B3;
            end
            // t2 = b3
            bsc_pkg::ST_P_B3:
            begin
                x = bsc_pkg::asr(mp, 5'd11) + t2_reg;
                t2_next = bsc_pkg::asr((((ac1 << 2) + x) << oss_reg) + 32'd2, 5'd2);
                ma = ac3;
                mb = t0_reg;
                state_next = bsc_pkg::ST_P_X1B;
            end
            bsc_pkg::ST_P_X1B:
            begin
                t3_next = bsc_pkg::asr(mp, 5'd13);
                ma = b1;
                mb = t1_reg;
                state_next = bsc_pkg::ST_P_X2B;
            end
            bsc_pkg::ST_P_X2B:
            begin
                x = bsc_pkg::asr(t3_reg + bsc_pkg::asr(mp, 5'd16) + 32'd2, 5'd2);
                ma = ac4;
                mb = x + bsc_pkg::C_32768;
                state_next = bsc_pkg::ST_P_B4;
            end
            // t3 = b4
            bsc_pkg::ST_P_B4:
            begin
                t3_next = mp >> 15;
                ma = up - t2_reg;
                mb = bsc_pkg::C_50000 >> oss_reg;
                state_next = bsc_pkg::ST_P_B7;
            end
            // t1 = b7
            bsc_pkg::ST_P_B7:
            begin
                t1_next = mp;
                state_next = bsc_pkg::ST_P_DIV;
            end
            bsc_pkg::ST_P_DIV:
            begin
                if (t3_reg == '0)
                begin
                    err_next = 1'b1;
                    state_next = bsc_pkg::ST_OUT;
                end
                else
                begin
                    dnum = t1_reg[31] ? t1_reg : (t1_reg << 1);
                    dden = t3_reg;
                    dstart = 1'b1;
                    state_next = bsc_pkg::ST_P_WAIT;
                end
            end
            bsc_pkg::ST_P_WAIT:
            begin
                if (!dbusy)
                    state_next = bsc_pkg::ST_P_Q;
            end
            // t0 = p
            bsc_pkg::ST_P_Q:
            begin
                x = t1_reg[31] ? (dq << 1) : dq;
                t0_next = x;
                ma = bsc_pkg::asr(x, 5'd8);
                mb = ma;
                state_next = bsc_pkg::ST_P_F1;
            end
            bsc_pkg::ST_P_F1:
            begin
                ma = mp;
                mb = bsc_pkg::C_3038;
                state_next = bsc_pkg::ST_P_F2;
            end
            bsc_pkg::ST_P_F2:
            begin
                t2_next = bsc_pkg::asr(mp, 5'd16);
                ma = bsc_pkg::C_M7357;
                mb = t0_reg;
                state_next = bsc_pkg::ST_P_F3;
            end
            bsc_pkg::ST_P_F3:
            begin
                x = t2_reg + bsc_pkg::asr(mp, 5'd16) + bsc_pkg::C_3791;
                val_next = t0_reg + bsc_pkg::asr(x, 5'd4);
                state_next = bsc_pkg::ST_P_END;
            end
            bsc_pkg::ST_P_END:
            begin
                state_next = bsc_pkg::ST_OUT;
            end
            bsc_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = bsc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bsc_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
